>>> design/path_sanitizer_assert.svh
`ifndef PATH_SANITIZER_ASSERT_SVH
`define PATH_SANITIZER_ASSERT_SVH

// condition and consequence in the same cycle
`define PS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define PS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/pathsan_pkg.sv
`default_nettype none

package pathsan_pkg;

	// lexer position within the current component
	typedef enum logic [1:0] {
		MODE_START,
		MODE_DOT1,
		MODE_DOT2,
		MODE_COPY
	} lex_mode_t;

	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_DOT   = 8'h2e;
	localparam logic [7:0] CHR_SLASH = 8'h2f;

	localparam int UPDIR_W     = 8;
	localparam int MAX_RESULTS = 3;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PW     = 2;

	typedef logic [1:0] res_count_t;
	typedef logic [2:0] fifo_count_t;

	// stack memory control for one accepted byte
	typedef struct packed {
		logic push;
		logic refill;
	} stack_op_t;

endpackage

`default_nettype wire

>>> design/pathsan_stack.sv
`default_nettype none

module pathsan_stack import pathsan_pkg::*; #(
	parameter int DEPTH = 2048,
	parameter int DW    = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  stack_op_t                op,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	input  logic [DW-1:0]            wdata,
	output logic [DW-1:0]            top
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;
	logic [DW-1:0] top_q;
	logic          refill_q;

	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refill_q <= 1'b0;
		end else begin
			refill_q <= op.refill;
		end
	end

	// cached top of stack, reloaded from memory in the cycle after a pop
	always_ff @(posedge clk) begin
		top_q <= op.push ? wdata : top;
	end

	assign top = refill_q ? rdata_q : top_q;

endmodule

`default_nettype wire

>>> design/path_sanitizer.sv
// queue: the words of an accepted byte are registered into a four-word queue
// throughput: one byte per cycle while each byte yields at most one word and
//   write_ready is high; the output port drains one word per cycle, and bytes
//   yielding two or three words hold the input until one word or none is left
// reset: arst_n clears all control state at once; the component stack memory
//   is not cleared and needs no clearing pass, only pushed entries are read
`default_nettype none

module path_sanitizer import pathsan_pkg::*; #(
	parameter int MAX_PATH       = 4096,
	parameter int MAX_COMPONENTS = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [UPDIR_W-1:0]          cfg_write_data,
	input  logic                        path_valid,
	output logic                        path_ready,
	input  logic [7:0]                  path_byte,
	output logic                        write_valid,
	input  logic                        write_ready,
	output logic [$clog2(MAX_PATH)-1:0] write_pos,
	output logic [7:0]                  write_byte,
	output logic                        path_done,
	output logic                        overflowed
);

	localparam int PW = $clog2(MAX_PATH);
	localparam int AW = $clog2(MAX_COMPONENTS);
	localparam int CW = $clog2(MAX_COMPONENTS + 1);

	// content bytes stop one short of the buffer end so the terminator fits
	localparam logic [PW-1:0]   PUT_LIMIT  = PW'(MAX_PATH - 1);
	localparam logic [CW-1:0]   STACK_FULL = CW'(MAX_COMPONENTS);
	localparam fifo_count_t     READY_MAX  = fifo_count_t'(FIFO_DEPTH - MAX_RESULTS);

	// path state
	lex_mode_t            mode_q, mode_d;
	logic [PW-1:0]        len_q;
	logic [PW-1:0]        floor_q;
	logic [UPDIR_W-1:0]   left_q;
	logic [UPDIR_W-1:0]   allowance_q;
	logic                 kept_q;
	logic [CW-1:0]        cnt_q;
	logic                 ovf_q;

	// step results
	logic [PW-1:0]        len_v;
	logic [PW-1:0]        floor_v;
	logic [UPDIR_W-1:0]   left_v;
	logic                 kept_v;
	logic [CW-1:0]        cnt_v;
	logic                 ovf_v;
	logic                 push_v;
	logic                 pop_v;
	logic                 fin_v;
	logic                 floor_set_v;
	res_count_t           np_v;
	res_count_t           n_v;
	logic [7:0]           put_b    [MAX_RESULTS];
	logic [PW-1:0]        res_pos  [MAX_RESULTS];
	logic [7:0]           res_byte [MAX_RESULTS];
	logic                 res_done [MAX_RESULTS];

	// component start stack
	stack_op_t            stk_op;
	logic [PW-1:0]        stack_top;
	logic [AW-1:0]        rd_addr;

	// result queue
	logic [PW-1:0]        fpos_q  [FIFO_DEPTH];
	logic [7:0]           fbyte_q [FIFO_DEPTH];
	logic                 fdone_q [FIFO_DEPTH];
	logic                 fovf_q  [FIFO_DEPTH];
	logic [FIFO_PW-1:0]   wptr_q;
	logic [FIFO_PW-1:0]   rptr_q;
	fifo_count_t          fcnt_q;

	logic                 in_fire;
	logic                 out_fire;

	assign path_ready = (fcnt_q <= READY_MAX);
	assign in_fire    = path_valid && path_ready;
	assign out_fire   = write_valid && write_ready;

	// lexer next state; a terminator always returns to start of component
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_START: begin
				if (path_byte == CHR_DOT) begin
					mode_d = MODE_DOT1;
				end else if (path_byte != CHR_NUL && path_byte != CHR_SLASH) begin
					mode_d = MODE_COPY;
				end
			end
			MODE_DOT1: begin
				if (path_byte == CHR_NUL || path_byte == CHR_SLASH) begin
					mode_d = MODE_START;
				end else if (path_byte == CHR_DOT) begin
					mode_d = MODE_DOT2;
				end else begin
					mode_d = MODE_COPY;
				end
			end
			MODE_DOT2: begin
				if (path_byte == CHR_NUL || path_byte == CHR_SLASH) begin
					mode_d = MODE_START;
				end else begin
					mode_d = MODE_COPY;
				end
			end
			MODE_COPY: begin
				if (path_byte == CHR_NUL || path_byte == CHR_SLASH) begin
					mode_d = MODE_START;
				end
			end
			default: mode_d = MODE_START;
		endcase
	end

	// per-byte datapath: decide pushes, pops and the bytes to put, then place them
	always_comb begin
		len_v       = len_q;
		floor_v     = floor_q;
		left_v      = left_q;
		kept_v      = kept_q;
		cnt_v       = cnt_q;
		ovf_v       = ovf_q;
		push_v      = 1'b0;
		pop_v       = 1'b0;
		fin_v       = 1'b0;
		floor_set_v = 1'b0;
		np_v        = '0;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			put_b[k] = CHR_DOT;
		end

		unique case (mode_q)
			MODE_START: begin
				if (path_byte == CHR_NUL) begin
					fin_v = 1'b1;
				end else if (path_byte != CHR_DOT && path_byte != CHR_SLASH) begin
					push_v   = 1'b1;
					put_b[0] = path_byte;
					np_v     = res_count_t'(1);
				end
			end
			MODE_DOT1: begin
				if (path_byte == CHR_NUL) begin
					fin_v = 1'b1;
				end else if (path_byte != CHR_DOT && path_byte != CHR_SLASH) begin
					// a lone dot turned out to be text
					push_v   = 1'b1;
					put_b[1] = path_byte;
					np_v     = res_count_t'(2);
				end
			end
			MODE_DOT2: begin
				if (path_byte == CHR_NUL || path_byte == CHR_SLASH) begin
					if (left_q != '0 && len_q == floor_q) begin
						// parent component kept at the floor; on a slash the floor moves past it
						left_v = left_q - UPDIR_W'(1);
						kept_v = 1'b1;
						np_v   = res_count_t'(2);
						if (path_byte == CHR_SLASH) begin
							put_b[2]    = CHR_SLASH;
							np_v        = res_count_t'(3);
							floor_set_v = 1'b1;
						end
					end else begin
						kept_v = 1'b0;
						pop_v  = (len_q != floor_q);
					end
					fin_v = (path_byte == CHR_NUL);
				end else begin
					// two dots followed by text
					push_v   = 1'b1;
					put_b[2] = path_byte;
					np_v     = res_count_t'(3);
				end
			end
			MODE_COPY: begin
				if (path_byte == CHR_NUL) begin
					fin_v = 1'b1;
				end else begin
					put_b[0] = path_byte;
					np_v     = res_count_t'(1);
				end
			end
			default: ;
		endcase

		// new component start, dropped when the stack is full
		if (push_v) begin
			kept_v = 1'b0;
			if (cnt_q < STACK_FULL) begin
				cnt_v = cnt_q + CW'(1);
			end else begin
				ovf_v = 1'b1;
			end
		end

		// back up over the last kept component, or to the floor on an empty stack
		if (pop_v) begin
			if (cnt_q != '0) begin
				cnt_v = cnt_q - CW'(1);
				len_v = stack_top;
			end else begin
				len_v = floor_q;
			end
		end

		// empty result becomes "." (a dot byte is queued ahead of the terminator)
		if (fin_v && len_v == floor_v && !kept_v) begin
			np_v = np_v + res_count_t'(1);
		end

		n_v = '0;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			res_pos[k]  = '0;
			res_byte[k] = CHR_NUL;
			res_done[k] = 1'b0;
		end
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (res_count_t'(k) < np_v) begin
				if (len_v < PUT_LIMIT) begin
					res_pos[n_v]  = len_v;
					res_byte[n_v] = put_b[k];
					n_v           = n_v + res_count_t'(1);
					len_v         = len_v + PW'(1);
				end else begin
					ovf_v = 1'b1;
				end
			end
		end

		if (floor_set_v) begin
			floor_v = len_v;
		end

		if (fin_v) begin
			res_pos[n_v]  = len_v;
			res_byte[n_v] = CHR_NUL;
			res_done[n_v] = 1'b1;
			n_v           = n_v + res_count_t'(1);
		end
	end

	// stack memory: push writes at the count, a pop refetches the next entry down
	assign rd_addr       = AW'(cnt_q - CW'(2));
	assign stk_op.push   = in_fire && push_v && (cnt_q < STACK_FULL);
	assign stk_op.refill = in_fire && pop_v && (cnt_q > CW'(1));

	pathsan_stack #(
		.DEPTH (MAX_COMPONENTS),
		.DW    (PW)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (stk_op),
		.waddr  (cnt_q[AW-1:0]),
		.raddr  (rd_addr),
		.wdata  (len_q),
		.top    (stack_top)
	);

	// path state; the terminator starts a fresh path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_START;
			len_q       <= '0;
			floor_q     <= '0;
			left_q      <= '0;
			allowance_q <= '0;
			kept_q      <= 1'b0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				allowance_q <= cfg_write_data;
			end
			if (in_fire) begin
				if (fin_v) begin
					mode_q  <= MODE_START;
					len_q   <= '0;
					floor_q <= '0;
					left_q  <= allowance_q;
					kept_q  <= 1'b0;
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
				end else begin
					mode_q  <= mode_d;
					len_q   <= len_v;
					floor_q <= floor_v;
					left_q  <= left_v;
					kept_q  <= kept_v;
					cnt_q   <= cnt_v;
					ovf_q   <= ovf_v;
				end
			end else if (cfg_write_en && len_q == '0 && mode_q == MODE_START) begin
				// untouched path picks up the new allowance at once
				left_q <= cfg_write_data;
			end
		end
	end

	// result queue payload; all words of a byte carry the flag after that byte
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int k = 0; k < MAX_RESULTS; k++) begin
				if (res_count_t'(k) < n_v) begin
					fpos_q[wptr_q + FIFO_PW'(k)]  <= res_pos[k];
					fbyte_q[wptr_q + FIFO_PW'(k)] <= res_byte[k];
					fdone_q[wptr_q + FIFO_PW'(k)] <= res_done[k];
					fovf_q[wptr_q + FIFO_PW'(k)]  <= ovf_v;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fcnt_q <= '0;
		end else begin
			if (in_fire) begin
				wptr_q <= wptr_q + FIFO_PW'(n_v);
			end
			if (out_fire) begin
				rptr_q <= rptr_q + FIFO_PW'(1);
			end
			fcnt_q <= fcnt_q + (in_fire ? fifo_count_t'(n_v) : '0)
				- (out_fire ? fifo_count_t'(1) : '0);
		end
	end

	assign write_valid = (fcnt_q != '0);
	assign write_pos   = fpos_q[rptr_q];
	assign write_byte  = fbyte_q[rptr_q];
	assign path_done   = fdone_q[rptr_q];
	assign overflowed  = fovf_q[rptr_q];

endmodule

`default_nettype wire

>>> design/pathsan_checker.sv
`default_nettype none

module pathsan_checker import pathsan_pkg::*; #(
	parameter int MAX_PATH = 4096
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        path_ready,
	input logic                        write_valid,
	input logic                        write_ready,
	input logic [$clog2(MAX_PATH)-1:0] write_pos,
	input logic [7:0]                  write_byte,
	input logic                        path_done
);

	`include "path_sanitizer_assert.svh"

	localparam int PW = $clog2(MAX_PATH);

	// the last word of a path is always the terminator
	`PS_ASSERT_NOW(a_done_is_nul, clk, arst_n, write_valid && path_done, write_byte == CHR_NUL, "last word is not a terminator")

	// content words are nonzero and leave room for the terminator
	`PS_ASSERT_NOW(a_content_fits, clk, arst_n, write_valid && !path_done, write_byte != CHR_NUL && write_pos < PW'(MAX_PATH - 1), "content word is zero or past the buffer end")

	// a stalled word holds
	`PS_ASSERT_NEXT(a_out_hold, clk, arst_n, write_valid && !write_ready, write_valid && $stable(write_pos) && $stable(write_byte) && $stable(path_done), "stalled word changed")

	// an empty result queue never stalls the input
	`PS_ASSERT_NOW(a_idle_ready, clk, arst_n, !write_valid, path_ready, "input stalled with nothing to deliver")

endmodule

bind path_sanitizer pathsan_checker #(
	.MAX_PATH (MAX_PATH)
) u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.path_ready  (path_ready),
	.write_valid (write_valid),
	.write_ready (write_ready),
	.write_pos   (write_pos),
	.write_byte  (write_byte),
	.path_done   (path_done)
);

`default_nettype wire
